FILE: hw/rtl/pwmcap_pkg.sv
// Package for the PWM phase ratio capture block: widths, payload types.
// No dependencies.
package pwmcap_pkg;
  localparam int unsigned Channels = 8;
  localparam int unsigned ChBits   = 3;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned CfgBits  = 4;
  localparam logic [CfgBits-1:0] ActiveReset = 4'd2;
  localparam int unsigned QDepth   = 2;

  typedef struct packed {
    logic [ChBits-1:0] channel;
    logic              pin_level;
    logic [31:0]       timestamp_us;
  } event_t;

  typedef struct packed {
    logic [ChBits-1:0] out_channel;
    logic [31:0]       high_time_us;
    logic [31:0]       low_time_us;
    logic [31:0]       phase_ratio;
    logic              saturated;
  } result_t;

  // Work handed from front to back.
  typedef struct packed {
    logic [ChBits-1:0] channel;
    logic [31:0]       high_t;
    logic [31:0]       low_t;
  } job_t;

  typedef enum logic [1:0] {StIdle, StDiv, StOut} div_state_e;
endpackage

FILE: hw/rtl/pwmcap_if.sv
// Valid/ready channel interfaces for event and result requests.
// Depends on pwmcap_pkg.
interface pwmcap_event_if;
  logic                  valid;
  logic                  ready;
  pwmcap_pkg::event_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pwmcap_result_if;
  logic                  valid;
  logic                  ready;
  pwmcap_pkg::result_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pwmcap_front.sv
// Front end: filters events, keeps per-channel edge state, emits jobs.
// Depends on pwmcap_pkg.
module pwmcap_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pwmcap_pkg::CfgBits-1:0] active_i,
  input  logic                          ev_valid_i,
  output logic                          ev_ready_o,
  input  pwmcap_pkg::event_t            ev_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output pwmcap_pkg::job_t              job_o
);
  import pwmcap_pkg::*;

  logic [Channels-1:0] exp_rise_q;
  logic [31:0]         rise_q [Channels];
  logic [31:0]         fall_q [Channels];
  logic                accept, active, fire;
  logic [31:0]         rt, ft;

  assign ev_ready_o = job_ready_i;
  assign accept = ev_valid_i && ev_ready_o;
  assign active = ({1'b0, ev_i.channel} < active_i);
  assign rt = rise_q[ev_i.channel];
  assign ft = fall_q[ev_i.channel];
  assign fire = accept && active && !ev_i.pin_level && !exp_rise_q[ev_i.channel];

  assign job_valid_o   = fire;
  assign job_o.channel = ev_i.channel;
  assign job_o.low_t   = rt - ft;
  assign job_o.high_t  = ev_i.timestamp_us - rt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_rise_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        rise_q[i] <= '0;
        fall_q[i] <= '0;
      end
    end else if (accept && active) begin
      if (ev_i.pin_level) begin
        if (exp_rise_q[ev_i.channel]) begin
          rise_q[ev_i.channel]     <= ev_i.timestamp_us;
          exp_rise_q[ev_i.channel] <= 1'b0;
        end
      end else if (!exp_rise_q[ev_i.channel]) begin
        fall_q[ev_i.channel]     <= ev_i.timestamp_us;
        exp_rise_q[ev_i.channel] <= 1'b1;
      end
    end
  end
endmodule

FILE: hw/rtl/pwmcap_queue.sv
// Small FIFO of jobs between front and back.
// Depends on pwmcap_pkg.
module pwmcap_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  pwmcap_pkg::job_t wr_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output pwmcap_pkg::job_t rd_o
);
  import pwmcap_pkg::*;

  job_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'(QDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_o = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hw/rtl/pwmcap_back.sv
// Back end: restoring divider for the Q16.16 ratio and result register.
// Depends on pwmcap_pkg.
module pwmcap_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  pwmcap_pkg::job_t   job_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output pwmcap_pkg::result_t res_o
);
  import pwmcap_pkg::*;

  div_state_e state_q, state_d;
  job_t       job_q;
  logic [47:0] num_q;      // shifts out dividend bits, collects quotient
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic [33:0] trial;
  logic [32:0] rem_sh;
  logic        start, step, done;

  assign rem_sh = {rem_q[31:0], num_q[47]};
  assign trial  = {1'b0, rem_sh} - {2'b0, job_q.low_t};
  assign start  = (state_q == StIdle) && job_valid_i;
  assign step   = (state_q == StDiv);
  assign done   = step && (cnt_q == 6'd47);

  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        job_ready_o = 1'b1;
        if (job_valid_i) state_d = StDiv;
      end
      StDiv: if (done) state_d = StOut;
      StOut: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // Datapath: one quotient bit per cycle over 48 dividend bits.
  always_ff @(posedge clk_i) begin
    if (start) begin
      job_q <= job_i;
      num_q <= {job_i.high_t, 16'h0};
      rem_q <= '0;
      cnt_q <= '0;
    end else if (step) begin
      cnt_q <= cnt_q + 6'd1;
      if (!trial[33]) begin
        rem_q <= trial[32:0];
        num_q <= {num_q[46:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[46:0], 1'b0};
      end
    end
  end

  logic ovf;
  assign ovf = (job_q.low_t == 32'd0) || (num_q[47:32] != 16'd0);
  assign res_o.out_channel  = job_q.channel;
  assign res_o.high_time_us = job_q.high_t;
  assign res_o.low_time_us  = job_q.low_t;
  assign res_o.phase_ratio  = ovf ? 32'hFFFF_FFFF : num_q[31:0];
  assign res_o.saturated    = ovf;
endmodule

FILE: hw/rtl/multichannel_pwm_phase_ratio_capture.sv
// Top level of the multichannel PWM phase ratio capture block.
// Depends on pwmcap_pkg, pwmcap_if, pwmcap_front, pwmcap_queue, pwmcap_back.
//
//   port        dir  what moves
//   ev_if       in   edge event request: channel, pin level, timestamp
//   res_if      out  result request: channel, phases, Q16.16 ratio, flag
//   cfg_*       in   active channel count, written any cycle
//
// Events are taken one per cycle while the job queue has room; only
// completed periods enter the queue. The back end loads a job, runs the
// restoring divide over 48 dividend bits and holds the result until the
// sink takes it, then takes another. Reset clears all channel state at
// once. A stalled result sink fills the queue and then stalls events.
module multichannel_pwm_phase_ratio_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  pwmcap_event_if.sink    ev_if,
  pwmcap_result_if.source res_if
);
  import pwmcap_pkg::*;

  logic [CfgBits-1:0] active_q;
  logic job_v, job_r, q_v, q_r;
  job_t job, qjob;

  // Hold the active count; reset leaves two channels enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       active_q <= ActiveReset;
    else if (cfg_we_i) active_q <= cfg_wdata_i;
  end

  pwmcap_front u_front (
    .clk_i, .rst_ni, .active_i(active_q),
    .ev_valid_i(ev_if.valid), .ev_ready_o(ev_if.ready), .ev_i(ev_if.payload),
    .job_valid_o(job_v), .job_ready_i(job_r), .job_o(job)
  );

  pwmcap_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(job_v), .wr_ready_o(job_r), .wr_i(job),
    .rd_valid_o(q_v), .rd_ready_i(q_r), .rd_o(qjob)
  );

  pwmcap_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_v), .job_ready_o(q_r), .job_i(qjob),
    .res_valid_o(res_if.valid), .res_ready_i(res_if.ready), .res_o(res_if.payload)
  );
endmodule
